@@ design/wic_pkg.sv @@
// Package for the wake-on-input controller.
// Holds the item, result and configuration types, the event codes and the wrapping time compare.
// No dependencies.
package wic_pkg;

  localparam int NUM_SOURCES_DEF = 8;
  localparam int CFG_ADDR_W      = 4;
  localparam int CFG_DATA_W      = 32;
  localparam int TIME_W          = 32;
  localparam int CFG_VAL_W       = 16;

  localparam logic [CFG_VAL_W-1:0] DEBOUNCE_RST = 16'd750;
  localparam logic [CFG_VAL_W-1:0] GRACE_RST    = 16'd2000;
  localparam logic [CFG_VAL_W-1:0] RETRY_RST    = 16'd500;

  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_GRACE    = 2'd1;
  localparam logic [1:0] REG_RETRY    = 2'd2;

  localparam logic [2:0] MODE_REPORT   = 3'd0;
  localparam logic [2:0] MODE_USB      = 3'd1;
  localparam logic [2:0] MODE_TICK     = 3'd2;
  localparam logic [2:0] MODE_FORGET   = 3'd3;
  localparam logic [2:0] MODE_SUPPRESS = 3'd4;

  typedef struct packed {
    logic [2:0]        mode;
    logic [2:0]        source;
    logic              any_pressed;
    logic [TIME_W-1:0] now_ms;
    logic              host_mounted;
    logic              host_suspended;
    logic              suppress;
    logic              personality_ok;
    logic              advert_busy;
    logic              radio_accepts;
  } item_t;

  typedef struct packed {
    logic wake_attempt;
    logic wake_started;
    logic armed;
    logic input_pending;
    logic host_active;
  } result_t;

  typedef struct packed {
    logic [CFG_VAL_W-1:0] inactive_debounce_ms;
    logic [CFG_VAL_W-1:0] boot_grace_ms;
    logic [CFG_VAL_W-1:0] retry_interval_ms;
  } cfg_t;

  // a lies before b, modulo 2^32
  function automatic logic time_before(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] diff;
    diff = a - b;
    return diff[TIME_W-1];
  endfunction

endpackage

@@ design/wic_cfg.sv @@
// Configuration register file of the wake-on-input controller, APB-style port.
// Depends on wic_pkg.
module wic_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [wic_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [wic_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [wic_pkg::CFG_DATA_W-1:0]  prdata,
  output wic_pkg::cfg_t                   cfg
);
  import wic_pkg::*;

  logic [1:0] reg_idx;
  logic       wr;

  assign reg_idx = paddr[3:2];
  assign wr      = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inactive_debounce_ms <= DEBOUNCE_RST;
      cfg.boot_grace_ms        <= GRACE_RST;
      cfg.retry_interval_ms    <= RETRY_RST;
    end else if (wr) begin
      case (reg_idx)
        REG_DEBOUNCE: cfg.inactive_debounce_ms <= pwdata[CFG_VAL_W-1:0];
        REG_GRACE:    cfg.boot_grace_ms        <= pwdata[CFG_VAL_W-1:0];
        REG_RETRY:    cfg.retry_interval_ms    <= pwdata[CFG_VAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEBOUNCE: prdata = CFG_DATA_W'(cfg.inactive_debounce_ms);
      REG_GRACE:    prdata = CFG_DATA_W'(cfg.boot_grace_ms);
      REG_RETRY:    prdata = CFG_DATA_W'(cfg.retry_interval_ms);
      default:      prdata = '0;
    endcase
  end

endmodule

@@ design/wic_core.sv @@
// Controller state and the single-pass next-state logic for one event item.
// Depends on wic_pkg.
module wic_core #(
  parameter int NUM_SOURCES = wic_pkg::NUM_SOURCES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  wic_pkg::item_t    item,
  input  wic_pkg::cfg_t     cfg,
  output wic_pkg::result_t  res
);
  import wic_pkg::*;

  localparam int SRC_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;

  logic [NUM_SOURCES-1:0] held_active, held_active_next;
  logic [NUM_SOURCES-1:0] baselined, baselined_next;
  logic                   press_pending, press_pending_next;
  logic [SRC_W-1:0]       pending_source, pending_source_next;
  logic [TIME_W-1:0]      press_time, press_time_next;
  logic                   wake_armed, wake_armed_next;
  logic                   wake_sent, wake_sent_next;
  logic                   boot_seen, boot_seen_next;
  logic [TIME_W-1:0]      boot_time, boot_time_next;
  logic [TIME_W-1:0]      retry_time, retry_time_next;
  logic                   usb_mounted, usb_mounted_next;
  logic                   usb_suspended, usb_suspended_next;
  logic [TIME_W-1:0]      usb_change_time, usb_change_time_next;
  logic                   input_suppressed, input_suppressed_next;

  logic [SRC_W-1:0]  src;
  logic [TIME_W-1:0] boot_base, since, accept_at, boot_at, accept_eff;
  logic              pend_eff, attempt, started;

  assign src = (32'(item.source) < 32'(NUM_SOURCES)) ? SRC_W'(item.source) : '0;

  always_comb begin
    held_active_next      = held_active;
    baselined_next        = baselined;
    press_pending_next    = press_pending;
    pending_source_next   = pending_source;
    press_time_next       = press_time;
    wake_armed_next       = wake_armed;
    wake_sent_next        = wake_sent;
    boot_seen_next        = boot_seen;
    boot_time_next        = boot_time;
    retry_time_next       = retry_time;
    usb_mounted_next      = usb_mounted;
    usb_suspended_next    = usb_suspended;
    usb_change_time_next  = usb_change_time;
    input_suppressed_next = input_suppressed;
    attempt               = 1'b0;
    started               = 1'b0;

    boot_base  = boot_seen ? boot_time : item.now_ms;
    since      = (usb_change_time != '0) ? usb_change_time : boot_base;
    accept_at  = since + TIME_W'(cfg.inactive_debounce_ms);
    boot_at    = boot_base + TIME_W'(cfg.boot_grace_ms);
    accept_eff = time_before(accept_at, boot_at) ? boot_at : accept_at;
    pend_eff   = press_pending;

    case (item.mode)
      MODE_REPORT: begin
        if (!input_suppressed) begin
          if (!baselined[src]) begin
            held_active_next[src] = item.any_pressed;
            if (!item.any_pressed) baselined_next[src] = 1'b1;
          end else begin
            if (item.any_pressed && !held_active[src]) begin
              press_time_next     = item.now_ms;
              pending_source_next = src;
              press_pending_next  = 1'b1;
            end
            held_active_next[src] = item.any_pressed;
          end
        end
      end
      MODE_USB: begin
        if (item.host_mounted != usb_mounted || item.host_suspended != usb_suspended) begin
          usb_mounted_next     = item.host_mounted;
          usb_suspended_next   = item.host_suspended;
          usb_change_time_next = item.now_ms;
        end
      end
      MODE_TICK: begin
        boot_seen_next = 1'b1;
        boot_time_next = boot_base;
        if (!item.personality_ok || (!input_suppressed && usb_mounted && !usb_suspended)) begin
          wake_armed_next    = 1'b0;
          wake_sent_next     = 1'b0;
          press_pending_next = 1'b0;
          retry_time_next    = '0;
        end else if (input_suppressed) begin
          press_pending_next = 1'b0;
          retry_time_next    = '0;
        end else if (!time_before(item.now_ms, boot_at) &&
                     !time_before(item.now_ms, accept_at)) begin
          if (!wake_armed) begin
            wake_armed_next = 1'b1;
            if (press_pending && time_before(press_time, accept_eff)) pend_eff = 1'b0;
          end
          press_pending_next = pend_eff;
          if (pend_eff && !(retry_time != '0 && time_before(item.now_ms, retry_time))
              && !(wake_sent && item.advert_busy)) begin
            wake_sent_next = 1'b0;
            attempt        = 1'b1;
            if (item.radio_accepts) begin
              started            = 1'b1;
              wake_sent_next     = 1'b1;
              press_pending_next = 1'b0;
              retry_time_next    = '0;
            end else begin
              retry_time_next = item.now_ms + TIME_W'(cfg.retry_interval_ms);
            end
          end
        end
      end
      MODE_FORGET: begin
        if (press_pending && pending_source == src) begin
          press_pending_next = 1'b0;
          retry_time_next    = '0;
        end
        held_active_next[src] = 1'b0;
        baselined_next[src]   = 1'b0;
      end
      MODE_SUPPRESS: begin
        input_suppressed_next = item.suppress;
        if (item.suppress) begin
          press_pending_next = 1'b0;
          retry_time_next    = '0;
        end
      end
      default: ;
    endcase

    res.wake_attempt  = attempt;
    res.wake_started  = started;
    res.armed         = wake_armed_next;
    res.input_pending = press_pending_next;
    res.host_active   = usb_mounted_next && !usb_suspended_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_active      <= '0;
      baselined        <= '0;
      press_pending    <= 1'b0;
      pending_source   <= '0;
      press_time       <= '0;
      wake_armed       <= 1'b0;
      wake_sent        <= 1'b0;
      boot_seen        <= 1'b0;
      boot_time        <= '0;
      retry_time       <= '0;
      usb_mounted      <= 1'b0;
      usb_suspended    <= 1'b0;
      usb_change_time  <= '0;
      input_suppressed <= 1'b0;
    end else if (step) begin
      held_active      <= held_active_next;
      baselined        <= baselined_next;
      press_pending    <= press_pending_next;
      pending_source   <= pending_source_next;
      press_time       <= press_time_next;
      wake_armed       <= wake_armed_next;
      wake_sent        <= wake_sent_next;
      boot_seen        <= boot_seen_next;
      boot_time        <= boot_time_next;
      retry_time       <= retry_time_next;
      usb_mounted      <= usb_mounted_next;
      usb_suspended    <= usb_suspended_next;
      usb_change_time  <= usb_change_time_next;
      input_suppressed <= input_suppressed_next;
    end
  end

endmodule

@@ design/wake_on_input_controller_unit.sv @@
// Wake-on-input controller top level: input register, controller core, result register.
// Path: input register, core, result register. Throughput: one item per cycle unless out_ready stalls.
// The input stage takes a new item while a result waits, as long as the result register drains.
// Reset (rst, synchronous): clears all controller state and both valid flags,
// and loads the configuration registers with their defaults. Depends on wic_pkg, wic_cfg, wic_core.
module wake_on_input_controller_unit #(
  parameter int NUM_SOURCES = wic_pkg::NUM_SOURCES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [wic_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [wic_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [wic_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [2:0]                      mode,
  input  logic [2:0]                      source,
  input  logic                            any_pressed,
  input  logic [wic_pkg::TIME_W-1:0]      now_ms,
  input  logic                            host_mounted,
  input  logic                            host_suspended,
  input  logic                            suppress,
  input  logic                            personality_ok,
  input  logic                            advert_busy,
  input  logic                            radio_accepts,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            wake_attempt,
  output logic                            wake_started,
  output logic                            armed,
  output logic                            input_pending,
  output logic                            host_active
);
  import wic_pkg::*;

  cfg_t    cfg;
  item_t   item;
  logic    item_valid;
  logic    step;
  result_t res, result;

  assign pready = 1'b1;

  wic_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  assign step     = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.mode           <= mode;
      item.source         <= source;
      item.any_pressed    <= any_pressed;
      item.now_ms         <= now_ms;
      item.host_mounted   <= host_mounted;
      item.host_suspended <= host_suspended;
      item.suppress       <= suppress;
      item.personality_ok <= personality_ok;
      item.advert_busy    <= advert_busy;
      item.radio_accepts  <= radio_accepts;
    end
  end

  wic_core #(
    .NUM_SOURCES (NUM_SOURCES)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (item),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result <= res;
    end
  end

  assign wake_attempt  = result.wake_attempt;
  assign wake_started  = result.wake_started;
  assign armed         = result.armed;
  assign input_pending = result.input_pending;
  assign host_active   = result.host_active;

`ifndef NO_ASSERTIONS
  a_started_needs_attempt: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!wake_started || wake_attempt))
    else $error("wake started without an attempt");

  a_started_clears_pending: assert property (@(posedge clk) disable iff (rst)
    (out_valid && wake_started) |-> !input_pending)
    else $error("press still pending after a started wake");

  a_stall_only_on_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output backpressure");

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid straight after reset");
`endif

endmodule

@@ test/wake_on_input_controller_unit_tb.sv @@
// Testbench for wake_on_input_controller_unit: a directed table, then random events in phases
// with different register settings. Each status item is checked against a behavioural model
// or a typed row's value. Depends on wic_pkg and the design under design/.
`timescale 1ns / 1ps

module wake_on_input_controller_unit_tb;
  import wic_pkg::*;

  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;
  localparam int PHASE_ITEMS = 120;
  localparam int PHASES      = 5;

  typedef struct packed {
    item_t   it;
    logic    typed;
    result_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0, in_ready;
  logic out_valid, out_ready = 1'b0;
  logic wake_attempt, wake_started, armed, input_pending, host_active;
  item_t   drv = '0;
  logic    drv_typed = 1'b0;
  result_t drv_want = '0;

  int idle_pct = 37;
  int mismatches = 0;
  int items_sent = 0;
  int results_checked = 0;
  int attempts_seen = 0, starts_seen = 0, armed_seen = 0;
  logic [31:0] clock_ms = 32'h400;
  result_t status_due[$];
  dir_row_t dir_rows[$];

  // model state, initial values are the post-reset state
  logic [CFG_VAL_W-1:0] dbnc_ms  = DEBOUNCE_RST;
  logic [CFG_VAL_W-1:0] grace_ms = GRACE_RST;
  logic [CFG_VAL_W-1:0] retry_iv = RETRY_RST;
  logic held [8]         = '{default: 1'b0};
  logic neutral_seen [8] = '{default: 1'b0};
  logic pending = 1'b0;
  logic [2:0] press_src = '0;
  logic [31:0] press_ms = '0;
  logic arm_st = 1'b0, sent = 1'b0, booted = 1'b0;
  logic [31:0] boot_ms = '0, retry_ms = '0, change_ms = '0;
  logic mounted = 1'b0, suspended = 1'b0, muted = 1'b0;

  wake_on_input_controller_unit dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .mode(drv.mode), .source(drv.source), .any_pressed(drv.any_pressed),
    .now_ms(drv.now_ms), .host_mounted(drv.host_mounted),
    .host_suspended(drv.host_suspended), .suppress(drv.suppress),
    .personality_ok(drv.personality_ok), .advert_busy(drv.advert_busy),
    .radio_accepts(drv.radio_accepts),
    .out_valid(out_valid), .out_ready(out_ready),
    .wake_attempt(wake_attempt), .wake_started(wake_started), .armed(armed),
    .input_pending(input_pending), .host_active(host_active)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // a lies before b on the wrapping millisecond clock
  function automatic logic earlier(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  function automatic void drop_press();
    pending  = 1'b0;
    retry_ms = '0;
  endfunction

  function automatic result_t wake_predict(input item_t it);
    result_t r;
    logic [31:0] since, accept_at, boot_at;
    logic [2:0] s;
    r = '0;
    s = it.source;
    case (it.mode)
      MODE_REPORT: if (!muted) begin
        if (!neutral_seen[s]) begin
          held[s] = it.any_pressed;
          if (!it.any_pressed) neutral_seen[s] = 1'b1;
        end else begin
          if (it.any_pressed && !held[s]) begin
            press_ms  = it.now_ms;
            press_src = s;
            pending   = 1'b1;
          end
          held[s] = it.any_pressed;
        end
      end
      MODE_USB: if (it.host_mounted != mounted || it.host_suspended != suspended) begin
        mounted   = it.host_mounted;
        suspended = it.host_suspended;
        change_ms = it.now_ms;
      end
      MODE_TICK: begin
        if (!booted) begin
          booted  = 1'b1;
          boot_ms = it.now_ms;
        end
        if (!it.personality_ok || (mounted && !suspended && !muted)) begin
          arm_st = 1'b0;
          sent   = 1'b0;
          drop_press();
        end else if (muted) begin
          drop_press();
        end else begin
          since     = (change_ms != 0) ? change_ms : boot_ms;
          accept_at = since + 32'(dbnc_ms);
          boot_at   = boot_ms + 32'(grace_ms);
          if (!earlier(it.now_ms, boot_at) && !earlier(it.now_ms, accept_at)) begin
            if (!arm_st) begin
              arm_st = 1'b1;
              if (earlier(accept_at, boot_at)) accept_at = boot_at;
              if (pending && earlier(press_ms, accept_at)) pending = 1'b0;
            end
            if (pending && !(retry_ms != 0 && earlier(it.now_ms, retry_ms)) &&
                !(sent && it.advert_busy)) begin
              sent = 1'b0;
              r.wake_attempt = 1'b1;
              if (it.radio_accepts) begin
                r.wake_started = 1'b1;
                sent     = 1'b1;
                pending  = 1'b0;
                retry_ms = '0;
              end else begin
                retry_ms = it.now_ms + 32'(retry_iv);
              end
            end
          end
        end
      end
      MODE_FORGET: begin
        if (pending && press_src == s) drop_press();
        held[s]         = 1'b0;
        neutral_seen[s] = 1'b0;
      end
      MODE_SUPPRESS: begin
        muted = it.suppress;
        if (it.suppress) drop_press();
      end
      default: ;
    endcase
    r.armed         = arm_st;
    r.input_pending = pending;
    r.host_active   = mounted && !suspended;
    return r;
  endfunction

  function automatic item_t ev(input logic [2:0] m, input logic [2:0] s, input logic nn,
                               input logic [31:0] t, input logic [5:0] fl);
    item_t it;
    it.mode = m;
    it.source = s;
    it.any_pressed = nn;
    it.now_ms = t;
    // fl: mounted, suspended, suppress, personality_ok, advert_busy, radio_accepts
    {it.host_mounted, it.host_suspended, it.suppress, it.personality_ok,
     it.advert_busy, it.radio_accepts} = fl;
    return it;
  endfunction

  function automatic void field_check(input string name, input logic want, input logic got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s expected %b, got %b", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) out_ready <= ($urandom_range(99) >= idle_pct);

  always @(posedge clk) begin
    result_t want, got;
    if (!rst) begin
      if (in_valid && in_ready) begin
        want = wake_predict(drv);
        if (drv_typed) want = drv_want;
        status_due.push_back(want);
      end
      if (out_valid && out_ready) begin
        got = {wake_attempt, wake_started, armed, input_pending, host_active};
        if (status_due.size() == 0) begin
          mismatches++;
          $display("%0t: status item with none expected, got %b", $time, got);
        end else begin
          want = status_due.pop_front();
          field_check("wake_attempt", want.wake_attempt, got.wake_attempt);
          field_check("wake_started", want.wake_started, got.wake_started);
          field_check("armed", want.armed, got.armed);
          field_check("input_pending", want.input_pending, got.input_pending);
          field_check("host_active", want.host_active, got.host_active);
        end
        attempts_seen += got.wake_attempt;
        starts_seen   += got.wake_started;
        armed_seen    += got.armed;
        results_checked++;
      end
    end
  end

  task automatic send_item(input item_t it, input logic typed, input result_t want);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    drv       <= it;
    drv_typed <= typed;
    drv_want  <= want;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [CFG_VAL_W-1:0] val);
    logic [CFG_DATA_W-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // read back
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== {16'h0, val}) begin
      mismatches++;
      $display("%0t: register %0d readback expected %h, got %h", $time, idx, val, rd);
    end
    case (idx)
      REG_DEBOUNCE: dbnc_ms = val;
      REG_GRACE:    grace_ms = val;
      default:      retry_iv = val;
    endcase
  endtask

  task automatic make_event(output item_t it);
    int pick, step;
    pick = $urandom_range(99);
    step = $urandom_range(99);
    it.source         = ($urandom_range(99) < 70) ? 3'($urandom_range(3))
                                                  : 3'($urandom_range(7));
    it.any_pressed    = 1'($urandom_range(1));
    it.host_mounted   = 1'($urandom_range(1));
    it.host_suspended = 1'($urandom_range(1));
    it.suppress       = ($urandom_range(99) < 25);
    it.personality_ok = ($urandom_range(99) < 90);
    it.advert_busy    = ($urandom_range(99) < 40);
    it.radio_accepts  = ($urandom_range(99) < 60);
    if (step < 5) clock_ms += $urandom_range(70000);
    else if (step < 90) clock_ms += $urandom_range(300);
    it.now_ms = clock_ms;
    // rare stray timestamp, clock itself stays in order
    if ($urandom_range(99) == 0) it.now_ms = $urandom;
    if (pick < 30) it.mode = MODE_REPORT;
    else if (pick < 40) begin
      it.mode = MODE_USB;
      // keep the host mostly asleep so arming is reached
      if (it.host_mounted && !it.host_suspended && $urandom_range(1))
        it.host_suspended = 1'b1;
    end
    else if (pick < 75) it.mode = MODE_TICK;
    else if (pick < 85) it.mode = MODE_FORGET;
    else if (pick < 91) it.mode = MODE_SUPPRESS;
    else if (pick < 98) begin
      it.mode = MODE_REPORT;
      it.any_pressed = 1'b0;
    end
    else it.mode = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
  endtask

  initial begin
    item_t it;
    logic [CFG_VAL_W-1:0] d, g, r;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    dir_rows.push_back('{ev(MODE_SPARE_LO, 0, 0, 32'h0, 6'b000000), 1'b1, 5'b00000});
    dir_rows.push_back('{ev(MODE_TICK, 0, 0, 32'hFFFF_F000, 6'b000100), 1'b1, 5'b00000});
    dir_rows.push_back('{ev(MODE_REPORT, 3, 1, 32'hFFFF_F010, 6'b000000), 1'b0, '0});
    dir_rows.push_back('{ev(MODE_REPORT, 3, 0, 32'hFFFF_F020, 6'b000000), 1'b0, '0});
    dir_rows.push_back('{ev(MODE_USB, 0, 0, 32'hFFFF_F200, 6'b110000), 1'b0, '0});
    dir_rows.push_back('{ev(MODE_REPORT, 3, 1, 32'hFFFF_FD00, 6'b000000), 1'b0, '0});
    // rejected start whose retry time wraps to zero
    dir_rows.push_back('{ev(MODE_TICK, 0, 0, 32'hFFFF_FE0C, 6'b000100), 1'b0, '0});
    dir_rows.push_back('{ev(MODE_TICK, 0, 0, 32'hFFFF_FE10, 6'b000101), 1'b0, '0});
    dir_rows.push_back('{ev(MODE_REPORT, 3, 0, 32'h10, 6'b000000), 1'b0, '0});
    dir_rows.push_back('{ev(MODE_REPORT, 3, 1, 32'h20, 6'b000000), 1'b0, '0});
    dir_rows.push_back('{ev(MODE_TICK, 0, 0, 32'h30, 6'b000111), 1'b0, '0});
    dir_rows.push_back('{ev(MODE_TICK, 0, 0, 32'h40, 6'b000100), 1'b0, '0});
    dir_rows.push_back('{ev(MODE_TICK, 0, 0, 32'h50, 6'b000101), 1'b0, '0});
    dir_rows.push_back('{ev(MODE_TICK, 0, 0, 32'h300, 6'b000101), 1'b0, '0});
    dir_rows.push_back('{ev(MODE_REPORT, 3, 0, 32'h310, 6'b000000), 1'b0, '0});
    dir_rows.push_back('{ev(MODE_REPORT, 3, 1, 32'h320, 6'b000000), 1'b0, '0});
    dir_rows.push_back('{ev(MODE_SUPPRESS, 0, 0, 32'h330, 6'b001000), 1'b0, '0});
    dir_rows.push_back('{ev(MODE_TICK, 0, 0, 32'h350, 6'b000101), 1'b0, '0});
    dir_rows.push_back('{ev(MODE_SUPPRESS, 0, 0, 32'h360, 6'b000000), 1'b0, '0});
    dir_rows.push_back('{ev(MODE_REPORT, 7, 0, 32'h370, 6'b000000), 1'b0, '0});
    dir_rows.push_back('{ev(MODE_REPORT, 7, 1, 32'h380, 6'b000000), 1'b0, '0});
    dir_rows.push_back('{ev(MODE_FORGET, 7, 0, 32'h390, 6'b000000), 1'b0, '0});
    dir_rows.push_back('{ev(MODE_TICK, 0, 0, 32'h3A0, 6'b000000), 1'b0, '0});
    // change at time zero falls back to the boot time; then an unchanged state
    dir_rows.push_back('{ev(MODE_USB, 0, 0, 32'h0, 6'b100000), 1'b0, '0});
    dir_rows.push_back('{ev(MODE_USB, 0, 0, 32'h3B0, 6'b100000), 1'b0, '0});
    dir_rows.push_back('{ev(MODE_SPARE_HI, 7, 1, 32'hFFFF_FFFF, 6'b111111), 1'b0, '0});

    foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].want);

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        in_valid <= 1'b0;
        while (results_checked < items_sent) @(posedge clk);
        case (p)
          1: begin d = '0; g = '0; r = '0; end
          2: begin d = 16'hFFFF; g = 16'hFFFF; r = 16'hFFFF; end
          3: begin
            d = 16'($urandom_range(200));
            g = 16'($urandom_range(200));
            r = 16'($urandom_range(1, 50));
          end
          default: begin d = 16'hFFFF; g = '0; r = 16'd1; end
        endcase
        reg_write(REG_DEBOUNCE, d);
        reg_write(REG_GRACE, g);
        reg_write(REG_RETRY, r);
      end
      idle_pct = (p == 2) ? 0 : 37;
      repeat (PHASE_ITEMS) begin
        make_event(it);
        send_item(it, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;
    idle_pct = 37;

    while (results_checked < items_sent) @(posedge clk);
    repeat (4) @(posedge clk);
    if (status_due.size() != 0) begin
      mismatches += status_due.size();
      $display("%0t: %0d status items never arrived", $time, status_due.size());
    end

    $display("summary: %0d events, %0d status items checked over %0d register settings",
             items_sent, results_checked, PHASES);
    $display("summary: %0d wake attempts, %0d started, %0d items armed, %0d mismatches",
             attempts_seen, starts_seen, armed_seen, mismatches);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
